### rtl/gpsct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS calendar time converter package
// Beat types, calendar and Julian-day constants, and the scaled reciprocals
// that replace most divisions by a constant in the datapath.
// ----------------------------------------------------------------------------
package gpsct_pkg;

  localparam int unsigned NumStages = 8;

  localparam longint unsigned MsPerMinute = 60000;
  localparam longint unsigned MsPerHour   = 3600000;
  localparam longint unsigned MsPerDay    = 86400000;
  localparam longint unsigned MsPerWeek   = 604800000;
  localparam longint unsigned WeekMax     = 8191;

  localparam longint unsigned YearBase     = 1980;
  localparam longint unsigned DaysPerYear  = 365;
  localparam longint unsigned DaysPerWeek  = 7;
  localparam longint unsigned DaysToEpoch  = 6;
  localparam longint unsigned JdBase       = 2444245 + 1537;
  localparam longint unsigned JdYearBase   = 4715;
  localparam longint unsigned JdYearScale  = 100;
  localparam longint unsigned JdYearOff    = 12210;
  localparam longint unsigned JdYearLen    = 36525;
  localparam longint unsigned JdMonthScale = 10000;
  localparam longint unsigned JdMonthLen   = 306001;

  // Each quotient estimate is floor(x * floor(2^K / D) / 2^K) for x below 2^K,
  // which is the true quotient or one less; one compare and subtract fixes it.
  localparam int unsigned     Div7K  = 21;
  localparam longint unsigned Div7M  = (64'd1 << Div7K) / DaysPerWeek;
  localparam int unsigned     YrK    = 28;
  localparam longint unsigned YrM    = (64'd1 << YrK) / JdYearLen;
  localparam longint unsigned YrMul  = JdYearScale * YrM;
  localparam longint unsigned YrOff  = JdYearOff * YrM;
  localparam int unsigned     HrK    = 27;
  localparam longint unsigned HrM    = (64'd1 << HrK) / MsPerHour;
  localparam int unsigned     MinK   = 22;
  localparam longint unsigned MinM   = (64'd1 << MinK) / MsPerMinute;
  localparam int unsigned     FK     = 23;
  localparam longint unsigned FM     = (64'd1 << FK) / JdMonthLen;
  localparam longint unsigned FMul   = JdMonthScale * FM;
  localparam int unsigned     DK     = 23;
  localparam longint unsigned DM     = (64'd1 << DK) / JdMonthScale;
  localparam longint unsigned DMul   = JdMonthLen * DM;

  typedef struct packed {
    logic        cmd;
    logic [12:0] week;
    logic [29:0] week_ms;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] minute_ms;
  } gpsct_in_t;

  typedef struct packed {
    logic [12:0] week;
    logic [29:0] week_ms;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] minute_ms;
    logic        bad_input;
  } gpsct_out_t;

  typedef struct packed {
    logic advance;
    logic in_valid;
  } gpsct_flow_t;

  function automatic logic [8:0] month_start(logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

### rtl/gpsct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS calendar time converter datapath
// Eight-stage pipeline that carries both conversion directions side by side,
// with a valid bit per stage and one enable that stalls every stage at once.
// ----------------------------------------------------------------------------
module gpsct_core
  import gpsct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gpsct_flow_t flow_i,
  input  gpsct_in_t   in_i,
  output logic        out_valid_o,
  output gpsct_out_t  out_o
);

  logic [NumStages-1:0] vld_q, vld_d;

  assign vld_d = flow_i.advance ? {vld_q[NumStages-2:0], flow_i.in_valid} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: day count since 1980, and Julian day with the day of week.
  logic [11:0] s1_ye;
  logic [10:0] s1_leap;
  logic        s1_bad_date;
  logic [2:0]  s1_didx;
  logic        s1_bad_d;
  logic [20:0] s1_days_d;
  logic [21:0] s1_c_d;
  logic [26:0] s1_msd_d;

  assign s1_ye       = in_i.year - 12'(YearBase);
  assign s1_leap     = 11'(s1_ye[11:2]) + 11'd1
                     - 11'((s1_ye[1:0] == 2'd0) && (in_i.month <= 4'd2));
  assign s1_bad_date = (in_i.year < 12'(YearBase)) || (in_i.month == 4'd0)
                     || (in_i.month > 4'd12);
  assign s1_days_d   = 21'(s1_ye) * 21'(DaysPerYear) + 21'(month_start(in_i.month))
                     + 21'(in_i.day) + 21'(s1_leap);

  always_comb begin
    s1_didx = '0;
    for (int k = 1; k < 7; k++) begin
      if (in_i.week_ms >= 30'(longint'(k) * MsPerDay)) begin
        s1_didx = s1_didx + 3'd1;
      end
    end
  end

  assign s1_msd_d = 27'(in_i.week_ms - 30'(s1_didx) * 30'(MsPerDay));
  assign s1_c_d   = 22'(in_i.week) * 22'(DaysPerWeek) + 22'(s1_didx) + 22'(JdBase);
  assign s1_bad_d = in_i.cmd ? (in_i.week_ms >= 30'(MsPerWeek)) : s1_bad_date;

  logic        s1_cmd_q, s1_bad_q;
  logic [20:0] s1_days_q;
  logic [4:0]  s1_hour_q;
  logic [5:0]  s1_minute_q;
  logic [15:0] s1_mms_q;
  logic [21:0] s1_c_q;
  logic [26:0] s1_msd_q;

  // Stage 2: quotient estimates for weeks, Julian years and hours, and the millisecond of day.
  logic [39:0] s2_prod7;
  logic [41:0] s2_yprod;
  logic [32:0] s2_hprod;
  logic        s2_bad_d;
  logic [20:0] s2_x_d;
  logic [18:0] s2_q7_d;
  logic [26:0] s2_tod_d;
  logic [12:0] s2_yq_d;
  logic [5:0]  s2_hq_d;

  assign s2_x_d   = s1_days_q - 21'(DaysToEpoch);
  assign s2_bad_d = s1_bad_q || (!s1_cmd_q && (s1_days_q < 21'(DaysToEpoch)));
  assign s2_prod7 = 40'(s2_x_d) * 40'(Div7M);
  assign s2_q7_d  = 19'(s2_prod7 >> Div7K);
  assign s2_tod_d = 27'(s1_hour_q) * 27'(MsPerHour) + 27'(s1_minute_q) * 27'(MsPerMinute)
                  + 27'(s1_mms_q);
  assign s2_yprod = 42'(s1_c_q) * 42'(YrMul) - 42'(YrOff);
  assign s2_yq_d  = 13'(s2_yprod >> YrK);
  assign s2_hprod = 33'(s1_msd_q) * 33'(HrM);
  assign s2_hq_d  = 6'(s2_hprod >> HrK);

  logic        s2_cmd_q, s2_bad_q;
  logic [20:0] s2_x_q;
  logic [18:0] s2_q7_q;
  logic [26:0] s2_tod_q;
  logic [21:0] s2_c_q;
  logic [26:0] s2_msd_q;
  logic [12:0] s2_yq_q;
  logic [5:0]  s2_hq_q;

  // Stage 3: quotient corrections.
  logic [20:0] s3_r7;
  logic        s3_ge7;
  logic [27:0] s3_t, s3_ry;
  logic        s3_yge;
  logic [26:0] s3_rh;
  logic        s3_hge;
  logic [18:0] s3_week_d;
  logic [2:0]  s3_rem_d;
  logic [12:0] s3_yr_d;
  logic [4:0]  s3_hour_d;
  logic [21:0] s3_remh_d;

  assign s3_r7     = s2_x_q - 21'(s2_q7_q) * 21'(DaysPerWeek);
  assign s3_ge7    = s3_r7 >= 21'(DaysPerWeek);
  assign s3_week_d = s2_q7_q + 19'(s3_ge7);
  assign s3_rem_d  = 3'(s3_ge7 ? s3_r7 - 21'(DaysPerWeek) : s3_r7);
  assign s3_t      = 28'(s2_c_q) * 28'(JdYearScale) - 28'(JdYearOff);
  assign s3_ry     = s3_t - 28'(s2_yq_q) * 28'(JdYearLen);
  assign s3_yge    = s3_ry >= 28'(JdYearLen);
  assign s3_yr_d   = s2_yq_q + 13'(s3_yge);
  assign s3_rh     = s2_msd_q - 27'(s2_hq_q) * 27'(MsPerHour);
  assign s3_hge    = s3_rh >= 27'(MsPerHour);
  assign s3_hour_d = 5'(s2_hq_q + 6'(s3_hge));
  assign s3_remh_d = 22'(s3_hge ? s3_rh - 27'(MsPerHour) : s3_rh);

  logic        s3_cmd_q, s3_bad_q;
  logic [18:0] s3_week_q;
  logic [2:0]  s3_rem_q;
  logic [26:0] s3_tod_q;
  logic [12:0] s3_yr_q;
  logic [4:0]  s3_hour_q;
  logic [21:0] s3_remh_q;
  logic [21:0] s3_c_q;

  // Stage 4: millisecond of week, day within the Julian year, minute estimate.
  logic [21:0] s4_e;
  logic [28:0] s4_mprod;
  logic [29:0] s4_ms_d;
  logic [8:0]  s4_g_d;
  logic [6:0]  s4_mq_d;

  assign s4_ms_d  = 30'(s3_rem_q) * 30'(MsPerDay) + 30'(s3_tod_q);
  assign s4_e     = 22'(s3_yr_q) * 22'(DaysPerYear) + 22'(s3_yr_q >> 2);
  assign s4_g_d   = 9'(s3_c_q - s4_e);
  assign s4_mprod = 29'(s3_remh_q) * 29'(MinM);
  assign s4_mq_d  = 7'(s4_mprod >> MinK);

  logic        s4_cmd_q, s4_bad_q;
  logic [18:0] s4_week_q;
  logic [29:0] s4_ms_q;
  logic [12:0] s4_yr_q;
  logic [4:0]  s4_hour_q;
  logic [21:0] s4_remh_q;
  logic [6:0]  s4_mq_q;
  logic [8:0]  s4_g_q;

  // Stage 5: week carry and range check, month estimate, minute correction.
  logic        s5_wrap;
  logic [27:0] s5_fprod;
  logic [21:0] s5_rm;
  logic        s5_mge;
  logic        s5_bad_d;
  logic [18:0] s5_week_d;
  logic [29:0] s5_ms_d;
  logic [4:0]  s5_fq_d;
  logic [5:0]  s5_minute_d;
  logic [15:0] s5_mms_d;

  assign s5_wrap     = s4_ms_q >= 30'(MsPerWeek);
  assign s5_ms_d     = s5_wrap ? s4_ms_q - 30'(MsPerWeek) : s4_ms_q;
  assign s5_week_d   = s4_week_q + 19'(s5_wrap);
  assign s5_bad_d    = s4_bad_q || (!s4_cmd_q && (s5_week_d > 19'(WeekMax)));
  assign s5_fprod    = 28'(s4_g_q) * 28'(FMul);
  assign s5_fq_d     = 5'(s5_fprod >> FK);
  assign s5_rm       = s4_remh_q - 22'(s4_mq_q) * 22'(MsPerMinute);
  assign s5_mge      = s5_rm >= 22'(MsPerMinute);
  assign s5_minute_d = 6'(s4_mq_q + 7'(s5_mge));
  assign s5_mms_d    = 16'(s5_mge ? s5_rm - 22'(MsPerMinute) : s5_rm);

  logic        s5_cmd_q, s5_bad_q;
  logic [18:0] s5_week_q;
  logic [29:0] s5_ms_q;
  logic [12:0] s5_yr_q;
  logic [4:0]  s5_hour_q;
  logic [5:0]  s5_minute_q;
  logic [15:0] s5_mms_q;
  logic [8:0]  s5_g_q;
  logic [4:0]  s5_fq_q;

  // Stage 6: month index correction.
  logic [22:0] s6_num, s6_rf;
  logic        s6_fge;
  logic [4:0]  s6_f_d;

  assign s6_num = 23'(s5_g_q) * 23'(JdMonthScale);
  assign s6_rf  = s6_num - 23'(s5_fq_q) * 23'(JdMonthLen);
  assign s6_fge = s6_rf >= 23'(JdMonthLen);
  assign s6_f_d = s5_fq_q + 5'(s6_fge);

  logic        s6_cmd_q, s6_bad_q;
  logic [18:0] s6_week_q;
  logic [29:0] s6_ms_q;
  logic [12:0] s6_yr_q;
  logic [4:0]  s6_hour_q;
  logic [5:0]  s6_minute_q;
  logic [15:0] s6_mms_q;
  logic [8:0]  s6_g_q;
  logic [4:0]  s6_f_q;

  // Stage 7: estimate of the days before the month starts.
  logic [33:0] s7_dprod;
  logic [9:0]  s7_dq_d;

  assign s7_dprod = 34'(s6_f_q) * 34'(DMul);
  assign s7_dq_d  = 10'(s7_dprod >> DK);

  logic        s7_cmd_q, s7_bad_q;
  logic [18:0] s7_week_q;
  logic [29:0] s7_ms_q;
  logic [12:0] s7_yr_q;
  logic [4:0]  s7_hour_q;
  logic [5:0]  s7_minute_q;
  logic [15:0] s7_mms_q;
  logic [8:0]  s7_g_q;
  logic [4:0]  s7_f_q;
  logic [9:0]  s7_dq_q;

  // Stage 8: day, month and year, then the result beat with unused fields zeroed.
  logic [23:0] s8_p, s8_rd;
  logic        s8_dge;
  logic [9:0]  s8_pd;
  logic [3:0]  s8_month;
  gpsct_out_t  out_d;
  gpsct_out_t  out_q;
  logic        out_cmd_q;

  assign s8_p     = 24'(s7_f_q) * 24'(JdMonthLen);
  assign s8_rd    = s8_p - 24'(s7_dq_q) * 24'(JdMonthScale);
  assign s8_dge   = s8_rd >= 24'(JdMonthScale);
  assign s8_pd    = s7_dq_q + 10'(s8_dge);
  assign s8_month = 4'(s7_f_q - 5'd1 - ((s7_f_q >= 5'd14) ? 5'd12 : 5'd0));

  always_comb begin
    out_d = '0;
    out_d.bad_input = s7_bad_q;
    if (!s7_bad_q) begin
      if (s7_cmd_q) begin
        out_d.year      = 12'(13'(s7_yr_q) - 13'(JdYearBase) - 13'(s8_month >= 4'd3));
        out_d.month     = s8_month;
        out_d.day       = 5'(10'(s7_g_q) - s8_pd);
        out_d.hour      = s7_hour_q;
        out_d.minute    = s7_minute_q;
        out_d.minute_ms = s7_mms_q;
      end else begin
        out_d.week    = 13'(s7_week_q);
        out_d.week_ms = s7_ms_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.advance) begin
      s1_cmd_q    <= in_i.cmd;
      s1_bad_q    <= s1_bad_d;
      s1_days_q   <= s1_days_d;
      s1_hour_q   <= in_i.hour;
      s1_minute_q <= in_i.minute;
      s1_mms_q    <= in_i.minute_ms;
      s1_c_q      <= s1_c_d;
      s1_msd_q    <= s1_msd_d;

      s2_cmd_q <= s1_cmd_q;
      s2_bad_q <= s2_bad_d;
      s2_x_q   <= s2_x_d;
      s2_q7_q  <= s2_q7_d;
      s2_tod_q <= s2_tod_d;
      s2_c_q   <= s1_c_q;
      s2_msd_q <= s1_msd_q;
      s2_yq_q  <= s2_yq_d;
      s2_hq_q  <= s2_hq_d;

      s3_cmd_q  <= s2_cmd_q;
      s3_bad_q  <= s2_bad_q;
      s3_week_q <= s3_week_d;
      s3_rem_q  <= s3_rem_d;
      s3_tod_q  <= s2_tod_q;
      s3_yr_q   <= s3_yr_d;
      s3_hour_q <= s3_hour_d;
      s3_remh_q <= s3_remh_d;
      s3_c_q    <= s2_c_q;

      s4_cmd_q  <= s3_cmd_q;
      s4_bad_q  <= s3_bad_q;
      s4_week_q <= s3_week_q;
      s4_ms_q   <= s4_ms_d;
      s4_yr_q   <= s3_yr_q;
      s4_hour_q <= s3_hour_q;
      s4_remh_q <= s3_remh_q;
      s4_mq_q   <= s4_mq_d;
      s4_g_q    <= s4_g_d;

      s5_cmd_q    <= s4_cmd_q;
      s5_bad_q    <= s5_bad_d;
      s5_week_q   <= s5_week_d;
      s5_ms_q     <= s5_ms_d;
      s5_yr_q     <= s4_yr_q;
      s5_hour_q   <= s4_hour_q;
      s5_minute_q <= s5_minute_d;
      s5_mms_q    <= s5_mms_d;
      s5_g_q      <= s4_g_q;
      s5_fq_q     <= s5_fq_d;

      s6_cmd_q    <= s5_cmd_q;
      s6_bad_q    <= s5_bad_q;
      s6_week_q   <= s5_week_q;
      s6_ms_q     <= s5_ms_q;
      s6_yr_q     <= s5_yr_q;
      s6_hour_q   <= s5_hour_q;
      s6_minute_q <= s5_minute_q;
      s6_mms_q    <= s5_mms_q;
      s6_g_q      <= s5_g_q;
      s6_f_q      <= s6_f_d;

      s7_cmd_q    <= s6_cmd_q;
      s7_bad_q    <= s6_bad_q;
      s7_week_q   <= s6_week_q;
      s7_ms_q     <= s6_ms_q;
      s7_yr_q     <= s6_yr_q;
      s7_hour_q   <= s6_hour_q;
      s7_minute_q <= s6_minute_q;
      s7_mms_q    <= s6_mms_q;
      s7_g_q      <= s6_g_q;
      s7_f_q      <= s6_f_q;
      s7_dq_q     <= s7_dq_d;

      out_q     <= out_d;
      out_cmd_q <= s7_cmd_q;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign out_o       = out_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_q.bad_input |->
      (out_q.week == '0) && (out_q.week_ms == '0) && (out_q.year == '0)
      && (out_q.month == '0) && (out_q.day == '0) && (out_q.hour == '0)
      && (out_q.minute == '0) && (out_q.minute_ms == '0))
    else $error("bad result carries non-zero fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_cmd_q && !out_q.bad_input |->
      (out_q.month >= 4'd1) && (out_q.month <= 4'd12) && (out_q.day >= 5'd1)
      && (out_q.hour < 5'd24) && (out_q.minute < 6'd60)
      && (out_q.minute_ms < 16'(MsPerMinute)) && (out_q.year >= 12'(YearBase))
      && (out_q.week == '0) && (out_q.week_ms == '0))
    else $error("calendar result out of range");

  a_gps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_cmd_q && !out_q.bad_input |->
      (out_q.week_ms < 30'(MsPerWeek)) && (out_q.year == '0) && (out_q.month == '0)
      && (out_q.day == '0) && (out_q.minute_ms == '0))
    else $error("GPS time result out of range");

endmodule

### rtl/gps_calendar_time_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS calendar time converter
// Converts a UTC calendar date to GPS week and millisecond of week, or back,
// as selected by the tuser bit of each input beat.
// ----------------------------------------------------------------------------
// Throughput is one beat per cycle; the eight-stage pipeline holds as a whole
// while a result beat waits on m_axis_tready.
// Reset clears the stage valid bits only; the block is ready straight away.
module gps_calendar_time_converter_unit
  import gpsct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_week, in_week_ms, in_year, in_month, in_day, in_hour, in_minute,
  // in_minute_ms, zero fill
  input  logic [95:0] s_axis_tdata,
  // command
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_week, out_week_ms, out_year, out_month, out_day, out_hour, out_minute,
  // out_minute_ms, zero fill
  output logic [95:0] m_axis_tdata,
  // bad_input
  output logic [0:0]  m_axis_tuser
);

  gpsct_in_t   in_beat;
  gpsct_out_t  out_beat;
  gpsct_flow_t flow;
  logic        out_valid;

  assign in_beat.cmd       = s_axis_tuser[0];
  assign in_beat.week      = s_axis_tdata[12:0];
  assign in_beat.week_ms   = s_axis_tdata[42:13];
  assign in_beat.year      = s_axis_tdata[54:43];
  assign in_beat.month     = s_axis_tdata[58:55];
  assign in_beat.day       = s_axis_tdata[63:59];
  assign in_beat.hour      = s_axis_tdata[68:64];
  assign in_beat.minute    = s_axis_tdata[74:69];
  assign in_beat.minute_ms = s_axis_tdata[90:75];

  assign flow.advance  = !out_valid || m_axis_tready;
  assign flow.in_valid = s_axis_tvalid;

  gpsct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_o       (out_beat)
  );

  assign s_axis_tready = flow.advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_beat.bad_input;
  assign m_axis_tdata  = {5'd0, out_beat.minute_ms, out_beat.minute, out_beat.hour,
                          out_beat.day, out_beat.month, out_beat.year,
                          out_beat.week_ms, out_beat.week};

endmodule
